### hdl/gcpd_pkg.sv
package gcpd_pkg;

   localparam int MAX_PIXELS       = 1048576;
   localparam int ADDR_BITS        = $clog2(MAX_PIXELS);
   localparam int MAX_CODE_BITS    = 16;
   localparam int PIXEL_INDEX_BITS = 20;
   localparam int PATTERN_BITS     = 4;
   localparam int SAMPLE_BITS      = 8;
   localparam int CODE_BITS_WIDTH  = 5;
   localparam int OFFSET_BITS      = 15;
   localparam int RESOLUTION_BITS  = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   localparam logic [SAMPLE_BITS-1:0] LEVEL_INVALID = 8'd255;

   localparam logic                       USE_INVERTED_RESET  = 1'b1;
   localparam logic [SAMPLE_BITS-1:0]     THRESHOLD_RESET     = 8'd0;
   localparam logic [CODE_BITS_WIDTH-1:0] CODE_BITS_RESET     = 5'd10;
   localparam logic [CODE_BITS_WIDTH-1:0] PATTERN_COUNT_RESET = 5'd10;
   localparam logic [OFFSET_BITS-1:0]     CODE_OFFSET_RESET   = 15'd0;
   localparam logic [RESOLUTION_BITS-1:0] RESOLUTION_RESET    = 16'd912;

   typedef enum logic [0:0] {
      OP_REFERENCE = 1'b0,
      OP_PATTERN   = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_USE_INVERTED  = 3'd0,
      CSR_THRESHOLD     = 3'd1,
      CSR_CODE_BITS     = 3'd2,
      CSR_PATTERN_COUNT = 3'd3,
      CSR_CODE_OFFSET   = 3'd4,
      CSR_RESOLUTION    = 3'd5
   } csr_index_type;

   typedef struct packed {
      op_type                      op;
      logic [PIXEL_INDEX_BITS-1:0] pixel_index;
      logic [PATTERN_BITS-1:0]     pattern_index;
      logic [SAMPLE_BITS-1:0]      bright_sample;
      logic [SAMPLE_BITS-1:0]      dark_sample;
   } req_type;

   typedef struct packed {
      logic [PIXEL_INDEX_BITS-1:0] pixel_index_res;
      logic [MAX_CODE_BITS-1:0]    code;
      logic                        valid_res;
      logic                        final_res;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [MAX_CODE_BITS-1:0] code;
   } code_entry_type;

endpackage

### hdl/gray_code_pixel_decoder_core.sv
// Per-pixel Gray code decoder.
// req channel: one request per pixel sample; op selects a reference request
// (all-on and all-off samples, albedo level and validity of the pixel) or a
// pattern request (one pattern bit folded into the pixel's code).
// rsp channel: exactly one result per request, in request order, carrying
// the pixel address, the code so far, the valid flag and the final flag.
// csr port: single-cycle register writes, to be done while the block is idle.
// Throughput: one request per cycle while rsp is not stalled, any mix of
// pixels; same-pixel back-to-back requests use forwarding, never stalling.
// Pipeline: a result reaches rsp after the request register (while the
// per-pixel code and level memories are read), the update stage (code fold,
// offset and range check, memory write) and the output register.
// The pipeline moves as a whole: when a result is stalled on rsp, req_stall
// goes high in the same cycle and every stage holds.
// Reset clears the pipeline and loads the register defaults. The code and
// level memories are not cleared: every pixel must get a reference
// request (in inverted mode, pattern 0) before use; this is not enforced.
module gray_code_pixel_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gcpd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gcpd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gcpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gcpd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   typedef struct packed {
      gcpd_pkg::op_type                            op;
      logic [gcpd_pkg::PIXEL_INDEX_BITS-1:0]       pixel_index;
      logic [gcpd_pkg::SAMPLE_BITS-1:0]            level;
      logic                                        ref_ok;
      logic                                        keep;
      logic                                        bit_set;
      logic [gcpd_pkg::MAX_CODE_BITS-1:0]          weight;
      logic                                        fin;
      logic                                        start;
      logic                                        fwd;
      gcpd_pkg::code_entry_type                    entry;
   } stage2_type;

   typedef struct packed {
      gcpd_pkg::rsp_type                rsp;
      gcpd_pkg::op_type                 op;
      logic [gcpd_pkg::SAMPLE_BITS-1:0] level;
   } stage3_type;

   logic                                       use_inverted_ff;
   logic [gcpd_pkg::SAMPLE_BITS-1:0]           threshold_ff;
   logic [gcpd_pkg::CODE_BITS_WIDTH-1:0]       code_bits_ff;
   logic [gcpd_pkg::CODE_BITS_WIDTH-1:0]       pattern_count_ff;
   logic [gcpd_pkg::OFFSET_BITS-1:0]           code_offset_ff;
   logic [gcpd_pkg::RESOLUTION_BITS-1:0]       resolution_ff;

   logic                                       en;
   logic                                       s1_valid_ff;
   gcpd_pkg::req_type                          s1_req_ff;
   logic                                       s2_valid_ff;
   stage2_type                                 s2_ff;
   stage2_type                                 s2_in;
   logic                                       s3_valid_ff;
   logic                                       s3_fresh_ff;
   stage3_type                                 s3_ff;
   stage3_type                                 s3_in;

   logic [gcpd_pkg::ADDR_BITS-1:0]             rd_addr;
   logic [gcpd_pkg::ADDR_BITS-1:0]             s1_addr;
   logic [gcpd_pkg::ADDR_BITS-1:0]             s2_addr;
   logic [gcpd_pkg::ADDR_BITS-1:0]             s3_addr;
   logic [$bits(gcpd_pkg::code_entry_type)-1:0] code_rd_raw;
   gcpd_pkg::code_entry_type                   code_rd;
   gcpd_pkg::code_entry_type                   code_wr;
   logic [gcpd_pkg::SAMPLE_BITS-1:0]           level_rd;
   logic                                       code_we;
   logic                                       level_we;

   logic [gcpd_pkg::SAMPLE_BITS-1:0]           ref_cur;
   logic [gcpd_pkg::SAMPLE_BITS-1:0]           other;
   logic [gcpd_pkg::SAMPLE_BITS:0]             diff;
   logic [gcpd_pkg::SAMPLE_BITS:0]             mag;
   logic [gcpd_pkg::SAMPLE_BITS:0]             level_sum;
   logic signed [6:0]                          wshift;

   gcpd_pkg::code_entry_type                   entry2;
   logic                                       entry_valid;
   logic [gcpd_pkg::MAX_CODE_BITS-1:0]         code0;
   logic [gcpd_pkg::MAX_CODE_BITS-1:0]         bitw;
   logic [gcpd_pkg::MAX_CODE_BITS-1:0]         code_new;
   logic [gcpd_pkg::MAX_CODE_BITS-1:0]         shifted;
   logic [gcpd_pkg::MAX_CODE_BITS:0]           limit;
   logic                                       below;
   logic                                       above;
   logic                                       pat_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_inverted_ff  <= gcpd_pkg::USE_INVERTED_RESET;
         threshold_ff     <= gcpd_pkg::THRESHOLD_RESET;
         code_bits_ff     <= gcpd_pkg::CODE_BITS_RESET;
         pattern_count_ff <= gcpd_pkg::PATTERN_COUNT_RESET;
         code_offset_ff   <= gcpd_pkg::CODE_OFFSET_RESET;
         resolution_ff    <= gcpd_pkg::RESOLUTION_RESET;
      end else if (csr_wr_en) begin
         case (gcpd_pkg::csr_index_type'(csr_index))
            gcpd_pkg::CSR_USE_INVERTED: begin
               use_inverted_ff <= csr_data[0];
            end
            gcpd_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_data[gcpd_pkg::SAMPLE_BITS-1:0];
            end
            gcpd_pkg::CSR_CODE_BITS: begin
               code_bits_ff <= csr_data[gcpd_pkg::CODE_BITS_WIDTH-1:0];
            end
            gcpd_pkg::CSR_PATTERN_COUNT: begin
               pattern_count_ff <= csr_data[gcpd_pkg::CODE_BITS_WIDTH-1:0];
            end
            gcpd_pkg::CSR_CODE_OFFSET: begin
               code_offset_ff <= csr_data[gcpd_pkg::OFFSET_BITS-1:0];
            end
            gcpd_pkg::CSR_RESOLUTION: begin
               resolution_ff <= csr_data[gcpd_pkg::RESOLUTION_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign en        = !s3_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_ff.rsp;

   assign s1_addr = gcpd_pkg::ADDR_BITS'(s1_req_ff.pixel_index);
   assign s2_addr = gcpd_pkg::ADDR_BITS'(s2_ff.pixel_index);
   assign s3_addr = gcpd_pkg::ADDR_BITS'(s3_ff.rsp.pixel_index_res);

   // re-read the held address while stalled so the data stays current
   assign rd_addr = en ? gcpd_pkg::ADDR_BITS'(req_data.pixel_index) : s1_addr;

   gcpd_ram #(
      .WIDTH ($bits(gcpd_pkg::code_entry_type)),
      .DEPTH (gcpd_pkg::MAX_PIXELS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (s2_addr),
      .wr_data (code_wr),
      .rd_addr (rd_addr),
      .rd_data (code_rd_raw)
   );

   gcpd_ram #(
      .WIDTH (gcpd_pkg::SAMPLE_BITS),
      .DEPTH (gcpd_pkg::MAX_PIXELS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (level_we),
      .wr_addr (s2_addr),
      .wr_data (s2_ff.level),
      .rd_addr (rd_addr),
      .rd_data (level_rd)
   );

   assign code_rd  = gcpd_pkg::code_entry_type'(code_rd_raw);
   assign code_we  = !reset && en && s2_valid_ff;
   assign level_we = code_we && (s2_ff.op == gcpd_pkg::OP_REFERENCE);

   // stage 1: forward pending writes, compare samples, derive weight
   always_comb begin
      if (s2_valid_ff && (s2_ff.op == gcpd_pkg::OP_REFERENCE) && (s2_addr == s1_addr)) begin
         ref_cur = s2_ff.level;
      end else if (s3_fresh_ff && (s3_ff.op == gcpd_pkg::OP_REFERENCE)
                   && (s3_addr == s1_addr)) begin
         ref_cur = s3_ff.level;
      end else begin
         ref_cur = level_rd;
      end

      other     = use_inverted_ff ? s1_req_ff.dark_sample : ref_cur;
      diff      = {1'b0, s1_req_ff.bright_sample} - {1'b0, other};
      mag       = diff[gcpd_pkg::SAMPLE_BITS] ? ((gcpd_pkg::SAMPLE_BITS+1)'(0) - diff) : diff;
      level_sum = {1'b0, s1_req_ff.bright_sample} + {1'b0, s1_req_ff.dark_sample};
      wshift    = $signed({2'b00, code_bits_ff}) - 7'sd1
                  - $signed({3'b000, s1_req_ff.pattern_index});

      s2_in.op          = s1_req_ff.op;
      s2_in.pixel_index = s1_req_ff.pixel_index;
      s2_in.ref_ok      = {2'b00, s1_req_ff.bright_sample}
                          >= ({2'b00, s1_req_ff.dark_sample} + {2'b00, threshold_ff});
      s2_in.level       = s2_in.ref_ok ? level_sum[gcpd_pkg::SAMPLE_BITS:1]
                                       : gcpd_pkg::LEVEL_INVALID;
      s2_in.bit_set     = !diff[gcpd_pkg::SAMPLE_BITS] && (diff != '0);
      s2_in.keep        = use_inverted_ff ? (mag >= {1'b0, threshold_ff})
                                          : (mag > {1'b0, threshold_ff});
      if ((code_bits_ff != '0) && (wshift >= 7'sd0)
          && (wshift < $signed(7'(gcpd_pkg::MAX_CODE_BITS)))) begin
         s2_in.weight = gcpd_pkg::MAX_CODE_BITS'(1) << wshift[3:0];
      end else begin
         s2_in.weight = '0;
      end
      s2_in.fin   = (s1_req_ff.op == gcpd_pkg::OP_PATTERN) && (pattern_count_ff != '0)
                    && ({1'b0, s1_req_ff.pattern_index} == (pattern_count_ff - 5'd1));
      s2_in.start = use_inverted_ff && (s1_req_ff.pattern_index == '0);
      s2_in.fwd   = s2_valid_ff && (s2_addr == s1_addr);
      if (s3_fresh_ff && (s3_addr == s1_addr)) begin
         s2_in.entry.valid = s3_ff.rsp.valid_res;
         s2_in.entry.code  = s3_ff.rsp.code;
      end else begin
         s2_in.entry = code_rd;
      end
   end

   // stage 2: fold the bit, apply offset and range check
   always_comb begin
      if (s2_ff.fwd) begin
         entry2.valid = s3_ff.rsp.valid_res;
         entry2.code  = s3_ff.rsp.code;
      end else begin
         entry2 = s2_ff.entry;
      end
      entry_valid = s2_ff.start || entry2.valid;
      code0       = s2_ff.start ? '0 : entry2.code;
      bitw        = s2_ff.bit_set ? s2_ff.weight : '0;
      code_new    = code0 | (bitw ^ ((code0 >> 1) & s2_ff.weight));
      limit       = {2'b00, code_offset_ff} + {1'b0, resolution_ff};
      below       = {1'b0, code_new} < {2'b00, code_offset_ff};
      above       = {1'b0, code_new} >= limit;
      shifted     = code_new - {1'b0, code_offset_ff};
      pat_valid   = entry_valid && s2_ff.keep && !(s2_ff.fin && (below || above));

      s3_in.op                  = s2_ff.op;
      s3_in.level               = s2_ff.level;
      s3_in.rsp.pixel_index_res = s2_ff.pixel_index;
      s3_in.rsp.final_res       = s2_ff.fin;
      if (s2_ff.op == gcpd_pkg::OP_REFERENCE) begin
         s3_in.rsp.valid_res = s2_ff.ref_ok;
         s3_in.rsp.code      = '0;
      end else begin
         s3_in.rsp.valid_res = pat_valid;
         s3_in.rsp.code      = pat_valid ? (s2_ff.fin ? shifted : code_new) : '0;
      end

      code_wr.valid = s3_in.rsp.valid_res;
      code_wr.code  = s3_in.rsp.code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_fresh_ff <= 1'b0;
      end else begin
         s3_fresh_ff <= en && s2_valid_ff;
         if (en) begin
            s1_valid_ff <= req_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= req_data;
         s2_ff     <= s2_in;
         s3_ff     <= s3_in;
      end
   end

endmodule

### hdl/gcpd_ram.sv
module gcpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/gcpd_checker.sv
module gcpd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input gcpd_pkg::req_type   req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input gcpd_pkg::rsp_type   rsp_data
);

   a_invalid_zero_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.code == '0)
      else $error("invalid result carries a nonzero code");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid && (rsp_data.pixel_index_res == $past(req_data.pixel_index, 3)))
      else $error("result missing or out of order three cycles after request");

   a_reference_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op == gcpd_pkg::OP_REFERENCE))
      ##1 !rsp_stall ##1 !rsp_stall
      |=> !rsp_data.final_res && (rsp_data.code == '0))
      else $error("reference request produced a final or nonzero-code result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind gray_code_pixel_decoder_core gcpd_checker u_checker (.*);
